[rtl/core/upq_pkg.sv]
// upq_pkg: types, codes and helpers shared by the updatable priority queue
// used by upq_cell, updatable_priority_queue and upq_checker; no dependencies
package upq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdW         = 16;
  localparam int unsigned PrioW       = 16;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 24;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_POLL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  // flags a cell shows to its neighbors
  typedef struct packed {
    logic occ;
    logic below;
    logic up_mv;
    logic dn_mv;
  } link_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins_en;
    logic upd_en;
    logic occ;
    logic sel;
    logic gt;
    logic lt;
  } cell_ctrl_t;

  // virtual neighbor below slot 0 ranks below everything
  localparam link_t LinkLowEdge  = '{occ: 1'b1, below: 1'b1, up_mv: 1'b0, dn_mv: 1'b0};
  localparam link_t LinkHighEdge = '{occ: 1'b0, below: 1'b0, up_mv: 1'b0, dn_mv: 1'b0};

  // true when a ranks strictly below b
  function automatic logic ranks_below(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else begin
      res = (a.id > b.id);
    end
    return res;
  endfunction

endpackage

[rtl/core/upq_cell.sv]
// upq_cell: one slot of the sorted chain, holds an event and trades it with its neighbors
// depends on upq_pkg
module upq_cell (
  input  logic                      clk_i,
  input  upq_pkg::cell_ctrl_t       ctrl_i,
  input  upq_pkg::entry_t           req_i,
  input  logic [upq_pkg::IdW-1:0]   probe_id_i,
  input  upq_pkg::entry_t           lo_entry_i,
  input  upq_pkg::link_t            lo_link_i,
  input  upq_pkg::entry_t           hi_entry_i,
  input  upq_pkg::link_t            hi_link_i,
  output upq_pkg::entry_t           entry_o,
  output upq_pkg::link_t            link_o,
  output logic                      match_o
);

  upq_pkg::entry_t entry_q, entry_d;
  logic below_w;
  logic above_w;
  logic landing_w;

  assign below_w = upq_pkg::ranks_below(entry_q, req_i);
  assign above_w = upq_pkg::ranks_below(req_i, entry_q);

  assign link_o.occ   = ctrl_i.occ;
  assign link_o.below = ctrl_i.occ && below_w;
  assign link_o.up_mv = ctrl_i.gt && ctrl_i.occ && below_w;
  assign link_o.dn_mv = ctrl_i.lt && ctrl_i.occ && above_w;

  // final slot of the updated event
  assign landing_w = (link_o.up_mv && !hi_link_i.up_mv)
                  || (link_o.dn_mv && !lo_link_i.dn_mv)
                  || (ctrl_i.sel && !hi_link_i.up_mv && !lo_link_i.dn_mv);

  assign match_o = ctrl_i.occ && (entry_q.id == probe_id_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (!link_o.below) begin
        if (lo_link_i.below) begin
          entry_d = req_i;
        end else if (lo_link_i.occ) begin
          entry_d = lo_entry_i;
        end
      end
    end else if (ctrl_i.upd_en) begin
      if (hi_link_i.up_mv) begin
        entry_d = hi_entry_i;
      end else if (lo_link_i.dn_mv) begin
        entry_d = lo_entry_i;
      end else if (landing_w) begin
        entry_d = req_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/core/updatable_priority_queue.sv]
// updatable_priority_queue: sorted event store built as a chain of upq_cell slots
// depends on upq_pkg and upq_cell
//
//  channel  | dir | tdata bits (low to high)                      | tlast/tuser
//  s_axis   | in  | operation[1:0] event_id[17:2] priority[33:18] | none
//  m_axis   | out | status[1:0] polled_id[17:2]                   | none
//
// each request is first captured, with ids matched across the chain, and then
// executed, with every cell comparing and shifting in parallel
// a result waiting in the output register stalls only the execute step
// reset clears the fill count; cell contents need no clearing
module updatable_priority_queue #(
  parameter int unsigned CAPACITY = upq_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [upq_pkg::InDataW-1:0]   s_axis_tdata,   // operation, event_id, priority_req
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [upq_pkg::OutDataW-1:0]  m_axis_tdata    // status, polled_id
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                      state_q, state_d;
  upq_pkg::op_e              op_q;
  upq_pkg::entry_t           req_q;
  logic [CAPACITY-1:0]       match_q;
  logic [CountW-1:0]         count_q, count_d;
  logic                      m_valid_q;
  logic [upq_pkg::OutDataW-1:0] m_data_q;

  logic                      accept_w;
  logic                      done_w;
  logic                      full_w;
  logic                      empty_w;
  logic                      found_w;
  logic [CAPACITY-1:0]       occ_w;
  logic [CAPACITY-1:0]       topsel_w;
  logic [CAPACITY-1:0]       match_w;
  logic [CAPACITY-1:0]       le_w;
  logic [CAPACITY-1:0]       sel_w;
  logic [CAPACITY-1:0]       lt_w;
  logic [CAPACITY-1:0]       gt_w;
  logic                      ins_en_w;
  logic                      upd_en_w;
  logic [upq_pkg::IdW-1:0]   probe_id_w;
  logic [upq_pkg::IdW-1:0]   polled_w;
  upq_pkg::status_e          status_w;
  logic [upq_pkg::IdW-1:0]   result_id_w;

  upq_pkg::entry_t           entry_w [CAPACITY];
  upq_pkg::link_t            link_w  [CAPACITY];

  assign s_axis_tready = (state_q == StIdle);
  assign accept_w      = s_axis_tvalid && s_axis_tready;
  assign done_w        = (state_q == StExec) && (!m_valid_q || m_axis_tready);
  assign probe_id_w    = s_axis_tdata[17:2];

  assign full_w  = (count_q == CountW'(CAPACITY));
  assign empty_w = (count_q == '0);
  assign found_w = |match_q;

  // lowest matching slot and the masks around it
  assign le_w  = match_q ^ (match_q - 1'b1);
  assign sel_w = le_w & match_q;
  assign lt_w  = le_w & ~match_q;
  assign gt_w  = ~le_w;

  assign ins_en_w = done_w && (op_q == upq_pkg::OP_INSERT) && !full_w;
  assign upd_en_w = done_w && (op_q == upq_pkg::OP_UPDATE) && found_w;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    upq_pkg::cell_ctrl_t ctrl;
    upq_pkg::entry_t     lo_entry;
    upq_pkg::link_t      lo_link;
    upq_pkg::entry_t     hi_entry;
    upq_pkg::link_t      hi_link;

    assign occ_w[k] = (CountW'(k) < count_q);

    if (k == 0) begin : g_lo_edge
      assign lo_entry = '0;
      assign lo_link  = upq_pkg::LinkLowEdge;
    end else begin : g_lo
      assign lo_entry = entry_w[k-1];
      assign lo_link  = link_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_hi_edge
      assign hi_entry    = '0;
      assign hi_link     = upq_pkg::LinkHighEdge;
      assign topsel_w[k] = occ_w[k];
    end else begin : g_hi
      assign hi_entry    = entry_w[k+1];
      assign hi_link     = link_w[k+1];
      assign topsel_w[k] = occ_w[k] && !occ_w[k+1];
    end

    assign ctrl.ins_en = ins_en_w;
    assign ctrl.upd_en = upd_en_w;
    assign ctrl.occ    = occ_w[k];
    assign ctrl.sel    = sel_w[k];
    assign ctrl.gt     = gt_w[k];
    assign ctrl.lt     = lt_w[k];

    upq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .req_i      (req_q),
      .probe_id_i (probe_id_w),
      .lo_entry_i (lo_entry),
      .lo_link_i  (lo_link),
      .hi_entry_i (hi_entry),
      .hi_link_i  (hi_link),
      .entry_o    (entry_w[k]),
      .link_o     (link_w[k]),
      .match_o    (match_w[k])
    );
  end

  // top of the order
  always_comb begin
    polled_w = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      polled_w = polled_w | (entry_w[k].id & {upq_pkg::IdW{topsel_w[k]}});
    end
  end

  always_comb begin
    status_w    = upq_pkg::ST_OK;
    result_id_w = '0;
    count_d     = count_q;
    unique case (op_q)
      upq_pkg::OP_INSERT: begin
        if (full_w) begin
          status_w = upq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      upq_pkg::OP_UPDATE: begin
        if (!found_w) begin
          status_w = upq_pkg::ST_NOT_FOUND;
        end
      end
      upq_pkg::OP_POLL: begin
        if (empty_w) begin
          status_w = upq_pkg::ST_EMPTY;
        end else begin
          result_id_w = polled_w;
          count_d     = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept_w) state_d = StExec;
      StExec: if (done_w) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_w) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      op_q         <= upq_pkg::op_e'(s_axis_tdata[1:0]);
      req_q.id     <= s_axis_tdata[17:2];
      req_q.prio   <= s_axis_tdata[33:18];
      match_q      <= match_w;
    end
    if (done_w) begin
      m_data_q <= {6'd0, result_id_w, status_w};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/core/upq_checker.sv]
// upq_checker: port-level assertions for updatable_priority_queue, bound to the top level
// depends on upq_pkg
module upq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [upq_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [upq_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic accept_w;
  assign accept_w = s_axis_tvalid && s_axis_tready;

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a request into a free output yields a result once it has been captured and then executed
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_w && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("result missing after request");

  // only a good poll returns an identifier
  a_polled_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[17:2] != '0)) |->
      (m_axis_tdata[1:0] == upq_pkg::ST_OK))
    else $error("identifier returned with error status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind updatable_priority_queue upq_checker u_upq_checker (.*);
